// File: hw/rtl/clr_pkg.sv
// Shared types and constants of the clipped line rasterizer.
// Used by every module of the block but clr_div; depends on nothing else.
package clr_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int PIXEL_BITS = 32;

  // Width of the signed clipping arithmetic and of the shared units.
  localparam int WORK_W     = 40;
  localparam int MUL_W      = 20;
  localparam int DVSR_W     = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [12:0] MAX_DIM_C = 13'(MAX_DIM);

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACHED = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH    = CFG_IDX_W'(4);

  // Bit positions of the line mode word.
  localparam int MODE_XDEC = 0;
  localparam int MODE_YDEC = 1;
  localparam int MODE_YMAJ = 2;
  localparam int MODE_DIAG = 3;
  localparam int MODE_BRES = 4;

  typedef logic signed [WORK_W-1:0] work_t;

  typedef struct packed {
    logic               req_type;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [31:0]        colour;
  } in_req_t;

  typedef struct packed {
    logic        pixel_valid;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [27:0] pixel_offset;
    logic [31:0] pixel_colour;
    logic        last_pixel;
    logic [12:0] pixel_count;
  } out_res_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ORIENT, ST_CHECK, ST_STRAIGHT, ST_DIAG1, ST_DIAG2,
    ST_BR_B1, ST_MUL_B1, ST_DIV_B1, ST_WAIT_B1,
    ST_BR_A1, ST_MUL_A1, ST_DIV_A1, ST_WAIT_A1,
    ST_BR_B2, ST_MUL_B2, ST_DIV_B2, ST_WAIT_B2,
    ST_CLAMP, ST_FINAL, ST_RESULT
  } ctrl_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_START, OP_STEP, OP_ORIENT, OP_CHECK, OP_STRAIGHT,
    OP_DIAG1, OP_DIAG2,
    OP_MUL_B1, OP_DIV_B1, OP_FIX_B1,
    OP_MUL_A1, OP_DIV_A1, OP_FIX_A1,
    OP_MUL_B2, OP_DIV_B2, OP_FIX_B2,
    OP_CLAMP, OP_FINAL, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic reject;
    logic straight;
    logic diag;
    logic b1_neg;
    logic a1_neg;
    logic b2_over;
    logic div_done;
  } sts_t;

endpackage

// File: hw/rtl/clr_div.sv
// Restoring divider, one quotient bit per cycle, for nonnegative operands.
// Uses no package items.
module clr_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 20
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             fits;
  logic [DEN_W-1:0] rem_nxt;
  logic [NUM_W-1:0] quo_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[NUM_W-1]};
    diff    = shifted - {1'b0, den_r};
    fits    = shifted >= {1'b0, den_r};
    rem_nxt = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    quo_nxt = {quo_r[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;
endmodule

// File: hw/rtl/clr_dp.sv
// Datapath: configuration registers, clipping arithmetic, line stepper and
// the result register. Depends on clr_pkg and instantiates clr_div.
module clr_dp #(
  parameter int PIXEL_BITS = clr_pkg::PIXEL_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  clr_pkg::cmd_t                      cmd,
  output clr_pkg::sts_t                      sts,
  input  clr_pkg::in_req_t                   in_data,
  input  logic                               cfg_we,
  input  logic [clr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [clr_pkg::CFG_DATA_W-1:0]     cfg_data,
  output clr_pkg::out_res_t                  out_data
);
  import clr_pkg::*;

  // Configuration.
  logic        attached_r, attached_nxt;
  logic [12:0] width_r, width_nxt;
  logic [12:0] height_r, height_nxt;
  logic [4:0]  stride_r, stride_nxt;
  logic [15:0] pitch_r, pitch_nxt;
  logic [4:0]  st_eff_r, st_eff_nxt;
  logic [16:0] pt_eff_r, pt_eff_nxt;
  logic [12:0] wdim_nxt, wdim, hdim;
  logic [17:0] pt_mul;
  work_t       w1, h1;
  logic        bm_ok;

  // Clipping registers.
  logic        xdec_r, ydec_r, swp_r, rej_r;
  work_t       mx1_r, mx2_r, my1_r, my2_r;
  work_t       a1_r, a2_r, b1_r, b2_r, ac_r, bc_r;
  work_t       A_r, B_r, e_r, p_r;
  logic [4:0]  mode_r;
  logic [12:0] count_r;
  logic [PIXEL_BITS-1:0] colour_r;

  // Line state.
  logic        act_r;
  logic [11:0] cx_r, cy_r;
  logic [12:0] left_r;
  work_t       err_r;
  logic [17:0] dec_r, inc_r;
  logic [4:0]  lmode_r;
  logic [PIXEL_BITS-1:0] lcol_r;
  out_res_t    out_r;

  // Helpers.
  work_t x1, y1, x2, y2, dx, dy, as_w, bs_w, A_w;
  work_t a1p, b1p, a2p, b2p, dn_a, dn_b, n_w, px, py, xo, yo;
  logic  fin_ok, is_straight, is_diag;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  work_t       bcb1;
  logic        div_go, div_done;
  logic [WORK_W-1:0] div_num, div_quo;
  logic [DVSR_W-1:0] div_den, div_rem;
  work_t       q_w, r_w;
  work_t       dec_w, inc_w, e_sub, e_add;
  logic        bres_hit, minor, step_x, step_y, last;
  logic [11:0] nx, ny;
  logic [28:0] off_sum;
  out_res_t    step_res, start_res;

  always_comb begin
    attached_nxt = attached_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    stride_nxt   = stride_r;
    pitch_nxt    = pitch_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_ATTACHED: attached_nxt = cfg_data[0];
        CFG_WIDTH:    width_nxt    = cfg_data[12:0];
        CFG_HEIGHT:   height_nxt   = cfg_data[12:0];
        CFG_STRIDE:   stride_nxt   = cfg_data[4:0];
        CFG_PITCH:    pitch_nxt    = cfg_data;
        default: ;
      endcase
    end
    st_eff_nxt = (stride_nxt == 5'd0) ? 5'd1 : stride_nxt;
    wdim_nxt   = (width_nxt > MAX_DIM_C) ? MAX_DIM_C : width_nxt;
    pt_mul     = 18'(st_eff_nxt) * 18'(wdim_nxt);
    pt_eff_nxt = (pitch_nxt != 16'd0) ? 17'(pitch_nxt) : pt_mul[16:0];
  end

  always_comb begin
    wdim  = (width_r > MAX_DIM_C) ? MAX_DIM_C : width_r;
    hdim  = (height_r > MAX_DIM_C) ? MAX_DIM_C : height_r;
    w1    = {{(WORK_W-13){1'b0}}, wdim} - work_t'(1);
    h1    = {{(WORK_W-13){1'b0}}, hdim} - work_t'(1);
    bm_ok = attached_r && (wdim != 13'd0) && (hdim != 13'd0);
    x1 = {{(WORK_W-16){in_data.start_x[15]}}, in_data.start_x};
    y1 = {{(WORK_W-16){in_data.start_y[15]}}, in_data.start_y};
    x2 = {{(WORK_W-16){in_data.end_x[15]}}, in_data.end_x};
    y2 = {{(WORK_W-16){in_data.end_y[15]}}, in_data.end_y};
  end

  // Orientation, classification and the direct clips.
  always_comb begin
    dx   = mx2_r - mx1_r;
    dy   = my2_r - my1_r;
    as_w = a2_r - a1_r;
    bs_w = b2_r - b1_r;
    A_w  = (as_w + work_t'(1)) <<< 1;
    is_straight = (bs_w == work_t'(0));
    is_diag     = (bs_w == as_w);

    a1p = (b1_r < 0) ? a1_r - b1_r : a1_r;
    b1p = (b1_r < 0) ? work_t'(0) : b1_r;
    a2p = (b2_r > bc_r) ? a2_r + (bc_r - b2_r) : a2_r;
    b2p = (b2_r > bc_r) ? bc_r : b2_r;

    dn_a = a2_r - a1_r;
    dn_b = b2_r - b1_r;
    if (mode_r[MODE_DIAG]) begin
      n_w = ((dn_b < dn_a) ? dn_b : dn_a) + work_t'(1);
    end else begin
      n_w = dn_a + work_t'(1);
    end
    fin_ok = !rej_r && (n_w > 0) && (a1_r >= 0) && (a1_r <= ac_r) &&
             (b1_r >= 0) && (b1_r <= bc_r);
    px = swp_r ? b1_r : a1_r;
    py = swp_r ? a1_r : b1_r;
    xo = xdec_r ? w1 - px : px;
    yo = ydec_r ? h1 - py : py;
  end

  // Shared multiplier operands and divider hookup.
  always_comb begin
    bcb1  = bc_r - b1_r;
    mul_a = A_r[MUL_W-1:0];
    mul_b = b1_r[MUL_W-1:0];
    case (cmd.op)
      OP_MUL_A1: begin
        mul_a = B_r[MUL_W-1:0];
        mul_b = a1_r[MUL_W-1:0];
      end
      OP_MUL_B2: mul_b = bcb1[MUL_W-1:0];
      default: ;
    endcase

    div_go  = 1'b0;
    div_num = e_r + p_r;
    div_den = B_r[DVSR_W-1:0];
    case (cmd.op)
      OP_DIV_B1: begin
        div_go  = 1'b1;
        div_num = e_r - p_r - A_r + B_r - work_t'(1);
      end
      OP_DIV_A1: begin
        div_go  = 1'b1;
        div_num = A_r - e_r - p_r;
        div_den = A_r[DVSR_W-1:0];
      end
      OP_DIV_B2: div_go = 1'b1;
      default: ;
    endcase
    q_w = div_quo;
    r_w = {{(WORK_W-DVSR_W){1'b0}}, div_rem};
  end

  clr_div #(
    .NUM_W(WORK_W),
    .DEN_W(DVSR_W)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo),
    .rem  (div_rem)
  );

  // Per-pixel stepping.
  always_comb begin
    dec_w    = {{(WORK_W-18){1'b0}}, dec_r};
    inc_w    = {{(WORK_W-18){1'b0}}, inc_r};
    e_sub    = err_r - dec_w;
    e_add    = e_sub + inc_w;
    bres_hit = lmode_r[MODE_BRES] && (e_sub <= 0);
    minor    = lmode_r[MODE_DIAG] || bres_hit;
    step_x   = !lmode_r[MODE_YMAJ] || minor;
    step_y   = lmode_r[MODE_YMAJ] || minor;
    nx       = cx_r + (lmode_r[MODE_XDEC] ? 12'hFFF : 12'd1);
    ny       = cy_r + (lmode_r[MODE_YDEC] ? 12'hFFF : 12'd1);
    last     = (left_r <= 13'd1);
    off_sum  = 29'(cx_r) * 29'(st_eff_r) + 29'(cy_r) * 29'(pt_eff_r);

    step_res = '0;
    if (act_r) begin
      step_res.pixel_valid  = 1'b1;
      step_res.pixel_x      = cx_r;
      step_res.pixel_y      = cy_r;
      step_res.pixel_offset = off_sum[27:0];
      step_res.pixel_colour = 32'(lcol_r);
      step_res.last_pixel   = last;
    end
    start_res             = '0;
    start_res.pixel_count = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attached_r <= 1'b0;
      width_r    <= '0;
      height_r   <= '0;
      stride_r   <= 5'd1;
      pitch_r    <= '0;
      st_eff_r   <= 5'd1;
      pt_eff_r   <= '0;
      act_r      <= 1'b0;
      left_r     <= '0;
    end else begin
      attached_r <= attached_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      stride_r   <= stride_nxt;
      pitch_r    <= pitch_nxt;
      st_eff_r   <= st_eff_nxt;
      pt_eff_r   <= pt_eff_nxt;
      case (cmd.op)
        OP_START: begin
          act_r  <= 1'b0;
          left_r <= '0;
        end
        OP_STEP: begin
          if (act_r) begin
            if (last) begin
              act_r  <= 1'b0;
              left_r <= '0;
            end else begin
              left_r <= left_r - 13'd1;
            end
          end
        end
        OP_FINAL: begin
          if (fin_ok) begin
            act_r  <= 1'b1;
            left_r <= n_w[12:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_START: begin
        xdec_r   <= x1 > x2;
        ydec_r   <= y1 > y2;
        mx1_r    <= (x1 > x2) ? w1 - x1 : x1;
        mx2_r    <= (x1 > x2) ? w1 - x2 : x2;
        my1_r    <= (y1 > y2) ? h1 - y1 : y1;
        my2_r    <= (y1 > y2) ? h1 - y2 : y2;
        colour_r <= in_data.colour[PIXEL_BITS-1:0];
        rej_r    <= 1'b0;
        count_r  <= '0;
      end
      OP_STEP: begin
        out_r <= step_res;
        if (act_r && !last) begin
          if (lmode_r[MODE_BRES]) begin
            err_r <= bres_hit ? e_add : e_sub;
          end
          if (step_x) begin
            cx_r <= nx;
          end
          if (step_y) begin
            cy_r <= ny;
          end
        end
      end
      OP_ORIENT: begin
        swp_r <= dy > dx;
        if (dy > dx) begin
          a1_r <= my1_r;
          a2_r <= my2_r;
          b1_r <= mx1_r;
          b2_r <= mx2_r;
          ac_r <= h1;
          bc_r <= w1;
        end else begin
          a1_r <= mx1_r;
          a2_r <= mx2_r;
          b1_r <= my1_r;
          b2_r <= my2_r;
          ac_r <= w1;
          bc_r <= h1;
        end
      end
      OP_CHECK: begin
        A_r    <= A_w;
        B_r    <= (bs_w + work_t'(1)) <<< 1;
        e_r    <= A_w - bs_w - work_t'(1);
        mode_r <= {!is_straight && !is_diag, is_diag && !is_straight, swp_r,
                   ydec_r, xdec_r};
      end
      OP_STRAIGHT: begin
        rej_r <= (b1_r < 0) || (b1_r > bc_r);
        if (a1_r < 0) begin
          a1_r <= '0;
        end
        if (a2_r > ac_r) begin
          a2_r <= ac_r;
        end
      end
      OP_DIAG1: begin
        if (a1p < 0) begin
          b1_r <= b1p - a1p;
          a1_r <= '0;
        end else begin
          b1_r <= b1p;
          a1_r <= a1p;
        end
      end
      OP_DIAG2: begin
        if (a2p > ac_r) begin
          b2_r <= b2p + (ac_r - a2p);
          a2_r <= ac_r;
        end else begin
          b2_r <= b2p;
          a2_r <= a2p;
        end
      end
      OP_MUL_B1, OP_MUL_A1, OP_MUL_B2: p_r <= mul_a * mul_b;
      OP_DIV_B1: e_r <= e_r - p_r;
      OP_DIV_A1: e_r <= e_r + p_r;
      OP_FIX_B1: begin
        e_r  <= A_r - B_r + work_t'(1) + r_w;
        a1_r <= a1_r + q_w;
        b1_r <= '0;
      end
      OP_FIX_A1: begin
        e_r  <= A_r - r_w;
        b1_r <= b1_r + q_w;
        a1_r <= '0;
      end
      OP_FIX_B2: a2_r <= a1_r + q_w;
      OP_CLAMP: begin
        if (a2_r > ac_r) begin
          a2_r <= ac_r;
        end
      end
      OP_FINAL: begin
        count_r <= fin_ok ? n_w[12:0] : 13'd0;
        if (fin_ok) begin
          cx_r    <= xo[11:0];
          cy_r    <= yo[11:0];
          err_r   <= e_r;
          dec_r   <= B_r[17:0];
          inc_r   <= A_r[17:0];
          lmode_r <= mode_r;
          lcol_r  <= colour_r;
        end
      end
      OP_EMIT: out_r <= start_res;
      default: ;
    endcase
  end

  always_comb begin
    sts.reject   = !bm_ok || !((a1_r <= ac_r) && (a2_r >= 0) &&
                               (b1_r <= bc_r) && (b2_r >= 0));
    sts.straight = is_straight;
    sts.diag     = is_diag;
    sts.b1_neg   = b1_r < 0;
    sts.a1_neg   = a1_r < 0;
    sts.b2_over  = b2_r > bc_r;
    sts.div_done = div_done;
  end

  assign out_data = out_r;
endmodule

// File: hw/rtl/clr_ctrl.sv
// Controller: sequences the clipping steps of a start request and the
// input and result handshakes. Depends on clr_pkg.
module clr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_start,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  clr_pkg::sts_t sts,
  output clr_pkg::cmd_t cmd
);
  import clr_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        accept, slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign accept    = (state_r == ST_IDLE) && in_valid && slot_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (accept && in_start) state_nxt = ST_ORIENT;
      ST_ORIENT:   state_nxt = ST_CHECK;
      ST_CHECK: begin
        if (sts.reject) begin
          state_nxt = ST_RESULT;
        end else if (sts.straight) begin
          state_nxt = ST_STRAIGHT;
        end else if (sts.diag) begin
          state_nxt = ST_DIAG1;
        end else begin
          state_nxt = ST_BR_B1;
        end
      end
      ST_STRAIGHT: state_nxt = ST_FINAL;
      ST_DIAG1:    state_nxt = ST_DIAG2;
      ST_DIAG2:    state_nxt = ST_FINAL;
      ST_BR_B1:    state_nxt = sts.b1_neg ? ST_MUL_B1 : ST_BR_A1;
      ST_MUL_B1:   state_nxt = ST_DIV_B1;
      ST_DIV_B1:   state_nxt = ST_WAIT_B1;
      ST_WAIT_B1:  if (sts.div_done) state_nxt = ST_BR_A1;
      ST_BR_A1:    state_nxt = sts.a1_neg ? ST_MUL_A1 : ST_BR_B2;
      ST_MUL_A1:   state_nxt = ST_DIV_A1;
      ST_DIV_A1:   state_nxt = ST_WAIT_A1;
      ST_WAIT_A1:  if (sts.div_done) state_nxt = ST_BR_B2;
      ST_BR_B2:    state_nxt = sts.b2_over ? ST_MUL_B2 : ST_CLAMP;
      ST_MUL_B2:   state_nxt = ST_DIV_B2;
      ST_DIV_B2:   state_nxt = ST_WAIT_B2;
      ST_WAIT_B2:  if (sts.div_done) state_nxt = ST_CLAMP;
      ST_CLAMP:    state_nxt = ST_FINAL;
      ST_FINAL:    state_nxt = ST_RESULT;
      ST_RESULT:   if (slot_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op = OP_NONE;
    case (state_r)
      ST_IDLE:     if (accept) cmd.op = in_start ? OP_START : OP_STEP;
      ST_ORIENT:   cmd.op = OP_ORIENT;
      ST_CHECK:    cmd.op = OP_CHECK;
      ST_STRAIGHT: cmd.op = OP_STRAIGHT;
      ST_DIAG1:    cmd.op = OP_DIAG1;
      ST_DIAG2:    cmd.op = OP_DIAG2;
      ST_MUL_B1:   cmd.op = OP_MUL_B1;
      ST_DIV_B1:   cmd.op = OP_DIV_B1;
      ST_WAIT_B1:  if (sts.div_done) cmd.op = OP_FIX_B1;
      ST_MUL_A1:   cmd.op = OP_MUL_A1;
      ST_DIV_A1:   cmd.op = OP_DIV_A1;
      ST_WAIT_A1:  if (sts.div_done) cmd.op = OP_FIX_A1;
      ST_MUL_B2:   cmd.op = OP_MUL_B2;
      ST_DIV_B2:   cmd.op = OP_DIV_B2;
      ST_WAIT_B2:  if (sts.div_done) cmd.op = OP_FIX_B2;
      ST_CLAMP:    cmd.op = OP_CLAMP;
      ST_FINAL:    cmd.op = OP_FINAL;
      ST_RESULT:   if (slot_free) cmd.op = OP_EMIT;
      default:     cmd.op = OP_NONE;
    endcase
    in_stall = (state_r != ST_IDLE) || !slot_free;
    if ((cmd.op == OP_STEP) || (cmd.op == OP_EMIT)) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
endmodule

// File: hw/rtl/clipped_line_rasterizer.sv
// Top level of the clipped line rasterizer: controller plus datapath.
// Depends on clr_pkg, clr_ctrl, clr_dp and clr_div.
//
//   Port group   Direction   Carries
//   in_*         into block  start or step request, in_req_t
//   out_*        out of      one result per request, out_res_t
//   cfg_*        into block  register writes, index and data
//
// Steps stream at one pixel per cycle unless the output stalls.
// A start request either ends after the reject check or may run up to three
// clip divisions in the restoring divider, one quotient bit per cycle.
// Reset is synchronous and active low; it clears the configuration registers and any line.
// A stalled result is held in the output register; the next request is taken
// in the cycle the held result leaves.
module clipped_line_rasterizer #(
  parameter int PIXEL_BITS = clr_pkg::PIXEL_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  clr_pkg::in_req_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output clr_pkg::out_res_t              out_data,
  input  logic                           cfg_we,
  input  logic [clr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [clr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import clr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  clr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_start (!in_data.req_type),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  clr_dp #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );
endmodule

// File: hw/rtl/clr_checker.sv
// Port-level checks on the result channel of the rasterizer, and the bind
// that attaches them to the top level. Depends on clr_pkg.
module clr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input clr_pkg::out_res_t out_data
);
  import clr_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_pixel_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.pixel_valid |-> out_data.pixel_count == 13'd0)
    else $error("pixel result carries a count");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.pixel_count <= MAX_DIM_C)
    else $error("pixel count beyond bitmap size");

  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.pixel_valid |->
      out_data.last_pixel == 1'b0 && out_data.pixel_offset == 28'd0 &&
      out_data.pixel_x == 12'd0 && out_data.pixel_colour == 32'd0)
    else $error("non-pixel result carries pixel fields");
endmodule

bind clipped_line_rasterizer clr_checker u_clr_checker (.*);
